/* hdl/etot_pkg.sv */
package etot_pkg;

    localparam int COORD_W = 10;
    localparam int WORD_W  = 32;
    localparam int DIST_W  = 31;
    localparam int LIMIT_W = 10;
    localparam int COUNT_W = 11;
    localparam int MODE_W  = 2;
    localparam int INDEX_W = 3;
    localparam int FRAC_W  = 24;

    localparam logic [INDEX_W-1:0] REG_PIXEL_STEP      = 3'd0;
    localparam logic [INDEX_W-1:0] REG_CENTRE_REAL     = 3'd1;
    localparam logic [INDEX_W-1:0] REG_CENTRE_IMAG     = 3'd2;
    localparam logic [INDEX_W-1:0] REG_TRAP_REAL       = 3'd3;
    localparam logic [INDEX_W-1:0] REG_TRAP_IMAG       = 3'd4;
    localparam logic [INDEX_W-1:0] REG_ITERATION_LIMIT = 3'd5;
    localparam logic [INDEX_W-1:0] REG_TRAP_MODE       = 3'd6;

    localparam logic [DIST_W-1:0]  RST_PIXEL_STEP      = 31'd16384;
    localparam logic [LIMIT_W-1:0] RST_ITERATION_LIMIT = 10'd255;

    typedef struct packed {
        logic        [DIST_W-1:0]  pixel_step;
        logic signed [WORD_W-1:0]  centre_real;
        logic signed [WORD_W-1:0]  centre_imag;
        logic signed [WORD_W-1:0]  trap_real;
        logic signed [WORD_W-1:0]  trap_imag;
        logic        [LIMIT_W-1:0] iteration_limit;
        logic        [MODE_W-1:0]  trap_mode;
    } t_cfg;

    typedef enum logic [2:0] {
        MUL_NONE = 3'd0,
        MUL_CR   = 3'd1,
        MUL_CI   = 3'd2,
        MUL_RR   = 3'd3,
        MUL_II   = 3'd4,
        MUL_RI   = 3'd5,
        MUL_DX   = 3'd6,
        MUL_DY   = 3'd7
    } t_mul;

    typedef struct packed {
        t_mul mul_sel;
        logic ld_pix;
        logic ld_cr;
        logic ld_ci;
        logic ld_rr;
        logic ld_diff;
        logic ld_z;
        logic ld_abs;
        logic upd_lin;
        logic ld_sx;
        logic upd_sq;
    } t_cmd;

    typedef struct packed {
        logic stop;
        logic sq_mode;
    } t_sts;

endpackage

/* hdl/etot_regs.sv */
module etot_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    input  logic [etot_pkg::INDEX_W-1:0]       i_cfg_index,
    input  logic [etot_pkg::WORD_W-1:0]        i_cfg_data,
    output etot_pkg::t_cfg                     o_cfg
);

    etot_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pixel_step      <= etot_pkg::RST_PIXEL_STEP;
            r_cfg.centre_real     <= '0;
            r_cfg.centre_imag     <= '0;
            r_cfg.trap_real       <= '0;
            r_cfg.trap_imag       <= '0;
            r_cfg.iteration_limit <= etot_pkg::RST_ITERATION_LIMIT;
            r_cfg.trap_mode       <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                etot_pkg::REG_PIXEL_STEP: begin
                    r_cfg.pixel_step <= i_cfg_data[etot_pkg::DIST_W-1:0];
                end
                etot_pkg::REG_CENTRE_REAL: begin
                    r_cfg.centre_real <= signed'(i_cfg_data);
                end
                etot_pkg::REG_CENTRE_IMAG: begin
                    r_cfg.centre_imag <= signed'(i_cfg_data);
                end
                etot_pkg::REG_TRAP_REAL: begin
                    r_cfg.trap_real <= signed'(i_cfg_data);
                end
                etot_pkg::REG_TRAP_IMAG: begin
                    r_cfg.trap_imag <= signed'(i_cfg_data);
                end
                etot_pkg::REG_ITERATION_LIMIT: begin
                    r_cfg.iteration_limit <= i_cfg_data[etot_pkg::LIMIT_W-1:0];
                end
                etot_pkg::REG_TRAP_MODE: begin
                    r_cfg.trap_mode <= i_cfg_data[etot_pkg::MODE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* hdl/etot_ctrl.sv */
module etot_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  etot_pkg::t_sts i_sts,
    output etot_pkg::t_cmd o_cmd,
    output logic           o_busy,
    output logic           o_result_valid
);

    typedef enum logic [13:0] {
        ST_IDLE = 14'b00000000000001,
        ST_CR   = 14'b00000000000010,
        ST_CI   = 14'b00000000000100,
        ST_CZ   = 14'b00000000001000,
        ST_RR   = 14'b00000000010000,
        ST_II   = 14'b00000000100000,
        ST_RI   = 14'b00000001000000,
        ST_ZU   = 14'b00000010000000,
        ST_AB   = 14'b00000100000000,
        ST_DL   = 14'b00001000000000,
        ST_SX   = 14'b00010000000000,
        ST_SY   = 14'b00100000000000,
        ST_DS   = 14'b01000000000000,
        ST_OUT  = 14'b10000000000000
    } t_state;

    t_state r_state;
    t_state n_state;
    etot_pkg::t_cmd cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        cmd.mul_sel = etot_pkg::MUL_NONE;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    cmd.ld_pix = 1'b1;
                    n_state    = ST_CR;
                end
            end
            ST_CR: begin
                cmd.mul_sel = etot_pkg::MUL_CR;
                n_state     = ST_CI;
            end
            ST_CI: begin
                cmd.mul_sel = etot_pkg::MUL_CI;
                cmd.ld_cr   = 1'b1;
                n_state     = ST_CZ;
            end
            ST_CZ: begin
                cmd.ld_ci = 1'b1;
                n_state   = ST_RR;
            end
            ST_RR: begin
                cmd.mul_sel = etot_pkg::MUL_RR;
                n_state     = ST_II;
            end
            ST_II: begin
                cmd.mul_sel = etot_pkg::MUL_II;
                cmd.ld_rr   = 1'b1;
                n_state     = ST_RI;
            end
            ST_RI: begin
                cmd.mul_sel = etot_pkg::MUL_RI;
                cmd.ld_diff = 1'b1;
                n_state     = i_sts.stop ? ST_OUT : ST_ZU;
            end
            ST_ZU: begin
                cmd.ld_z = 1'b1;
                n_state  = ST_AB;
            end
            ST_AB: begin
                cmd.ld_abs = 1'b1;
                n_state    = i_sts.sq_mode ? ST_SX : ST_DL;
            end
            ST_DL: begin
                cmd.upd_lin = 1'b1;
                n_state     = ST_RR;
            end
            ST_SX: begin
                cmd.mul_sel = etot_pkg::MUL_DX;
                n_state     = ST_SY;
            end
            ST_SY: begin
                cmd.mul_sel = etot_pkg::MUL_DY;
                cmd.ld_sx   = 1'b1;
                n_state     = ST_DS;
            end
            ST_DS: begin
                cmd.upd_sq = 1'b1;
                n_state    = ST_RR;
            end
            ST_OUT: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd          = cmd;
    assign o_busy         = (r_state != ST_IDLE);
    assign o_result_valid = (r_state == ST_OUT);

endmodule

/* hdl/etot_dp.sv */
module etot_dp #(
    parameter int HALF_WIDTH  = 512,
    parameter int HALF_HEIGHT = 512
) (
    input  logic                                      i_clk,
    input  etot_pkg::t_cfg                            i_cfg,
    input  etot_pkg::t_cmd                            i_cmd,
    input  logic signed [etot_pkg::COORD_W-1:0]       i_pixel_col,
    input  logic signed [etot_pkg::COORD_W-1:0]       i_pixel_row,
    output etot_pkg::t_sts                            o_sts,
    output logic        [etot_pkg::DIST_W-1:0]        o_trap_distance,
    output logic        [etot_pkg::COUNT_W-1:0]       o_iterations_run,
    output logic                                      o_escaped
);

    localparam int HW_BITS = $clog2(HALF_WIDTH) + 2;
    localparam int HH_BITS = $clog2(HALF_HEIGHT) + 2;
    localparam int XW = (HW_BITS > etot_pkg::COORD_W + 1) ? HW_BITS : etot_pkg::COORD_W + 1;
    localparam int YW = (HH_BITS > etot_pkg::COORD_W + 1) ? HH_BITS : etot_pkg::COORD_W + 1;
    localparam int PW = 2 * etot_pkg::WORD_W;
    localparam int SW = PW + 1;
    localparam logic signed [XW-1:0] XLO = XW'(-HALF_WIDTH);
    localparam logic signed [XW-1:0] XHI = XW'(HALF_WIDTH - 1);
    localparam logic signed [YW-1:0] YLO = YW'(-HALF_HEIGHT);
    localparam logic signed [YW-1:0] YHI = YW'(HALF_HEIGHT - 1);
    localparam logic [SW-1:0] ESC_BOUND = SW'(4) << (2 * etot_pkg::FRAC_W);
    localparam logic [etot_pkg::DIST_W-1:0] DIST_MAX = '1;

    function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] v);
        logic signed [31:0] r;
        if ((&v[SW-1:31]) || !(|v[SW-1:31])) begin
            r = v[31:0];
        end else if (v[SW-1]) begin
            r = {1'b1, 31'd0};
        end else begin
            r = {1'b0, {31{1'b1}}};
        end
        return r;
    endfunction

    function automatic logic [30:0] absd(input logic signed [31:0] a,
                                         input logic signed [31:0] b);
        logic signed [32:0] d;
        logic        [32:0] m;
        logic        [30:0] r;
        d = 33'(a) - 33'(b);
        m = d[32] ? 33'(-d) : 33'(d);
        if (|m[32:31]) begin
            r = '1;
        end else begin
            r = m[30:0];
        end
        return r;
    endfunction

    logic signed [XW-1:0] col_ext;
    logic signed [YW-1:0] row_ext;
    logic signed [XW-1:0] col_clamp;
    logic signed [YW-1:0] row_clamp;

    logic signed [XW-1:0]                   r_col;
    logic signed [YW-1:0]                   r_row;
    logic signed [31:0]                     r_cr;
    logic signed [31:0]                     r_ci;
    logic signed [31:0]                     r_zr;
    logic signed [31:0]                     r_zi;
    logic signed [PW-1:0]                   r_prod;
    logic signed [PW-1:0]                   r_rr;
    logic signed [PW-1:0]                   r_diff;
    logic        [PW-1:0]                   r_sx;
    logic        [etot_pkg::DIST_W-1:0]     r_dx;
    logic        [etot_pkg::DIST_W-1:0]     r_dy;
    logic        [etot_pkg::DIST_W-1:0]     r_best;
    logic        [etot_pkg::COUNT_W-1:0]    r_n;
    logic                                   r_esc;

    logic signed [31:0]                     mul_a;
    logic signed [31:0]                     mul_b;
    logic        [SW-1:0]                   sq_sum;
    logic                                   esc;
    logic        [etot_pkg::DIST_W-1:0]     d_lin;
    logic        [PW-1:0]                   e_sum;
    logic        [PW-etot_pkg::FRAC_W-1:0]  e_shr;
    logic        [etot_pkg::DIST_W-1:0]     d_sq;

    always_comb begin
        col_ext = XW'(i_pixel_col);
        row_ext = YW'(i_pixel_row);
        if (col_ext < XLO) begin
            col_clamp = XLO;
        end else if (col_ext > XHI) begin
            col_clamp = XHI;
        end else begin
            col_clamp = col_ext;
        end
        if (row_ext < YLO) begin
            row_clamp = YLO;
        end else if (row_ext > YHI) begin
            row_clamp = YHI;
        end else begin
            row_clamp = row_ext;
        end
    end

    always_comb begin
        unique case (i_cmd.mul_sel)
            etot_pkg::MUL_NONE: begin
                mul_a = '0;
                mul_b = '0;
            end
            etot_pkg::MUL_CR: begin
                mul_a = 32'(r_col);
                mul_b = signed'({1'b0, i_cfg.pixel_step});
            end
            etot_pkg::MUL_CI: begin
                mul_a = 32'(r_row);
                mul_b = signed'({1'b0, i_cfg.pixel_step});
            end
            etot_pkg::MUL_RR: begin
                mul_a = r_zr;
                mul_b = r_zr;
            end
            etot_pkg::MUL_II: begin
                mul_a = r_zi;
                mul_b = r_zi;
            end
            etot_pkg::MUL_RI: begin
                mul_a = r_zr;
                mul_b = r_zi;
            end
            etot_pkg::MUL_DX: begin
                mul_a = signed'({1'b0, r_dx});
                mul_b = signed'({1'b0, r_dx});
            end
            etot_pkg::MUL_DY: begin
                mul_a = signed'({1'b0, r_dy});
                mul_b = signed'({1'b0, r_dy});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        sq_sum = {1'b0, r_rr} + {1'b0, r_prod};
        esc    = (sq_sum >= ESC_BOUND);
        if (i_cfg.trap_mode[0] && (r_dx < r_dy)) begin
            d_lin = r_dx;
        end else begin
            d_lin = r_dy;
        end
        e_sum = r_sx + PW'(r_prod);
        e_shr = e_sum[PW-1:etot_pkg::FRAC_W];
        if (|e_shr[PW-etot_pkg::FRAC_W-1:etot_pkg::DIST_W]) begin
            d_sq = DIST_MAX;
        end else begin
            d_sq = e_shr[etot_pkg::DIST_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (i_cmd.ld_pix) begin
            r_col  <= col_clamp;
            r_row  <= row_clamp;
            r_zr   <= '0;
            r_zi   <= '0;
            r_n    <= '0;
            r_best <= DIST_MAX;
        end
        if (i_cmd.ld_cr) begin
            r_cr <= sat32(SW'(r_prod) + SW'(i_cfg.centre_real));
        end
        if (i_cmd.ld_ci) begin
            r_ci <= sat32(SW'(r_prod) + SW'(i_cfg.centre_imag));
        end
        if (i_cmd.ld_rr) begin
            r_rr <= r_prod;
        end
        if (i_cmd.ld_diff) begin
            r_diff <= r_rr - r_prod;
            r_esc  <= esc;
        end
        if (i_cmd.ld_z) begin
            r_zr <= sat32(SW'(r_diff >>> etot_pkg::FRAC_W) + SW'(r_cr));
            r_zi <= sat32(SW'(r_prod >>> (etot_pkg::FRAC_W - 1)) + SW'(r_ci));
            r_n  <= r_n + 1'b1;
        end
        if (i_cmd.ld_abs) begin
            r_dx <= absd(r_zr, i_cfg.trap_real);
            r_dy <= absd(r_zi, i_cfg.trap_imag);
        end
        if (i_cmd.upd_lin && (d_lin < r_best)) begin
            r_best <= d_lin;
        end
        if (i_cmd.ld_sx) begin
            r_sx <= PW'(r_prod);
        end
        if (i_cmd.upd_sq && (d_sq < r_best)) begin
            r_best <= d_sq;
        end
    end

    assign o_sts.stop    = esc || (r_n > etot_pkg::COUNT_W'(i_cfg.iteration_limit));
    assign o_sts.sq_mode = i_cfg.trap_mode[1];

    assign o_trap_distance  = r_best;
    assign o_iterations_run = r_n;
    assign o_escaped        = r_esc;

endmodule

/* hdl/escape_time_orbit_trap.sv */
// Channel   Handshake                         Word
// pixel     start / busy (accept: start&!busy) i_pixel_col, i_pixel_row
// result    o_result_valid, one-cycle strobe  o_trap_distance, o_iterations_run, o_escaped
// config    i_cfg_valid / o_cfg_ready         i_cfg_index, i_cfg_data
//
// One shared 32x32 multiplier issues one product per cycle and sets the pace.
// A pixel's time from accept to strobe grows with iterations_run and is longer in squared-distance
// mode, where each iteration passes through more states; busy drops the cycle after the strobe.
// Reset is synchronous, active low; it restores the register defaults.
// The receiver cannot stall: each result word is flagged valid for exactly one cycle.
module escape_time_orbit_trap #(
    parameter int HALF_WIDTH  = 512,
    parameter int HALF_HEIGHT = 512
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [etot_pkg::COORD_W-1:0]   i_pixel_col,
    input  logic signed [etot_pkg::COORD_W-1:0]   i_pixel_row,
    output logic                                  o_result_valid,
    output logic        [etot_pkg::DIST_W-1:0]    o_trap_distance,
    output logic        [etot_pkg::COUNT_W-1:0]   o_iterations_run,
    output logic                                  o_escaped,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic        [etot_pkg::INDEX_W-1:0]   i_cfg_index,
    input  logic        [etot_pkg::WORD_W-1:0]    i_cfg_data
);

    etot_pkg::t_cfg cfg;
    etot_pkg::t_cmd cmd;
    etot_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    etot_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    etot_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_sts          (sts),
        .o_cmd          (cmd),
        .o_busy         (busy),
        .o_result_valid (o_result_valid)
    );

    etot_dp #(
        .HALF_WIDTH  (HALF_WIDTH),
        .HALF_HEIGHT (HALF_HEIGHT)
    ) u_dp (
        .i_clk            (i_clk),
        .i_cfg            (cfg),
        .i_cmd            (cmd),
        .i_pixel_col      (i_pixel_col),
        .i_pixel_row      (i_pixel_row),
        .o_sts            (sts),
        .o_trap_distance  (o_trap_distance),
        .o_iterations_run (o_iterations_run),
        .o_escaped        (o_escaped)
    );

endmodule

/* tb/tb.sv */
module tb;
    import etot_pkg::*;

    localparam int HALF_WIDTH   = 512;
    localparam int HALF_HEIGHT  = 512;
    localparam int RANDOM_WORDS = 850;
    localparam int STALL_LIMIT  = 40000;
    localparam int TAIL_CYCLES  = 50;
    localparam int LIMIT_MAX    = (1 << LIMIT_W) - 1;
    localparam int RIM[4]       = '{-512, -1, 0, 511};

    localparam longint WORD_MAX = 64'sd2147483647;
    localparam longint WORD_MIN = -64'sd2147483648;
    localparam logic [63:0] ESCAPE_SQ = 64'd4 << (2 * FRAC_W);

    localparam logic [MODE_W-1:0] TRAP_VERTICAL = 2'd0;
    localparam logic [MODE_W-1:0] TRAP_CROSS    = 2'd1;
    localparam logic [MODE_W-1:0] TRAP_EUCLID   = 2'd2;
    localparam logic [MODE_W-1:0] TRAP_SPARE    = 2'd3;

    typedef enum logic [1:0] {
        WORK_PIXEL,
        WORK_CFG,
        WORK_DRAIN,
        WORK_IDLE
    } t_work_kind;

    typedef struct {
        t_work_kind                kind;
        logic signed [COORD_W-1:0] col;
        logic signed [COORD_W-1:0] row;
        logic [INDEX_W-1:0]        index;
        logic [WORD_W-1:0]         data;
        int                        idle_pct;
    } t_work;

    typedef struct {
        logic [DIST_W-1:0]  trap_distance;
        logic [COUNT_W-1:0] iterations_run;
        logic               escaped;
    } t_orbit;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic signed [COORD_W-1:0]  i_pixel_col = '0;
    logic signed [COORD_W-1:0]  i_pixel_row = '0;
    logic                       o_result_valid;
    logic [DIST_W-1:0]          o_trap_distance;
    logic [COUNT_W-1:0]         o_iterations_run;
    logic                       o_escaped;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [INDEX_W-1:0]         i_cfg_index = '0;
    logic [WORD_W-1:0]          i_cfg_data = '0;

    t_work  work_q[$];
    t_orbit trap_results_due[$];
    t_cfg   trap_cfg;
    int     idle_pct = 0;
    int     fail_count = 0;
    int     stall_cycles = 0;

    escape_time_orbit_trap #(
        .HALF_WIDTH (HALF_WIDTH),
        .HALF_HEIGHT(HALF_HEIGHT)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_pixel_col     (i_pixel_col),
        .i_pixel_row     (i_pixel_row),
        .o_result_valid  (o_result_valid),
        .o_trap_distance (o_trap_distance),
        .o_iterations_run(o_iterations_run),
        .o_escaped       (o_escaped),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic longint sat_word(longint v);
        if (v > WORD_MAX) return WORD_MAX;
        if (v < WORD_MIN) return WORD_MIN;
        return v;
    endfunction

    function automatic longint gap_sat(longint a, longint b);
        longint d;
        d = a - b;
        if (d < 0) d = -d;
        return (d > WORD_MAX) ? WORD_MAX : d;
    endfunction

    function automatic t_orbit predict_orbit(t_cfg cfg, logic signed [COORD_W-1:0] col_in,
                                             logic signed [COORD_W-1:0] row_in);
        longint      col, row, step, cr, ci, tr, ti;
        longint      zr, zi, nr, ni, dx, dy, d, best;
        logic [63:0] mag;
        int unsigned n;
        logic        out_of_disc;
        t_orbit      res;
        col = longint'(col_in);
        row = longint'(row_in);
        col = (col < -HALF_WIDTH) ? -HALF_WIDTH : (col > HALF_WIDTH - 1) ? HALF_WIDTH - 1 : col;
        row = (row < -HALF_HEIGHT) ? -HALF_HEIGHT :
              (row > HALF_HEIGHT - 1) ? HALF_HEIGHT - 1 : row;
        step = longint'(cfg.pixel_step);
        cr = sat_word(col * step + longint'($signed(cfg.centre_real)));
        ci = sat_word(row * step + longint'($signed(cfg.centre_imag)));
        tr = longint'($signed(cfg.trap_real));
        ti = longint'($signed(cfg.trap_imag));
        zr = 0;
        zi = 0;
        best = WORD_MAX;
        n = 0;
        out_of_disc = 1'b0;
        while (n <= cfg.iteration_limit && !out_of_disc) begin
            nr = sat_word(((zr * zr - zi * zi) >>> FRAC_W) + cr);
            ni = sat_word(((zr * zi) >>> (FRAC_W - 1)) + ci);
            zr = nr;
            zi = ni;
            n++;
            dx = gap_sat(zr, tr);
            dy = gap_sat(zi, ti);
            case (cfg.trap_mode)
                TRAP_VERTICAL: d = dy;
                TRAP_CROSS: d = (dx < dy) ? dx : dy;
                default: begin
                    d = (dx * dx + dy * dy) >>> FRAC_W;
                    if (d > WORD_MAX) d = WORD_MAX;
                end
            endcase
            if (d < best) best = d;
            mag = $unsigned(zr * zr) + $unsigned(zi * zi);
            out_of_disc = (mag >= ESCAPE_SQ);
        end
        res.trap_distance  = best[DIST_W-1:0];
        res.iterations_run = n[COUNT_W-1:0];
        res.escaped        = out_of_disc;
        return res;
    endfunction

    task automatic push_pixel(int col, int row);
        t_work w;
        w.kind = WORK_PIXEL;
        w.col  = COORD_W'(col);
        w.row  = COORD_W'(row);
        work_q.insert(work_q.size(), w);
    endtask

    task automatic push_cfg(logic [INDEX_W-1:0] index, logic [WORD_W-1:0] data);
        t_work w;
        w.kind  = WORK_CFG;
        w.index = index;
        w.data  = data;
        work_q.insert(work_q.size(), w);
    endtask

    task automatic push_drain();
        t_work w;
        w.kind = WORK_DRAIN;
        work_q.insert(work_q.size(), w);
    endtask

    task automatic push_idle(int pct);
        t_work w;
        w.kind     = WORK_IDLE;
        w.idle_pct = pct;
        work_q.insert(work_q.size(), w);
    endtask

    always @(posedge i_clk) begin : driver
        logic  nxt_start;
        logic  nxt_cfg_valid;
        logic  quiet;
        t_work w;
        nxt_start     = start;
        nxt_cfg_valid = i_cfg_valid;
        if (!i_rst_n) begin
            nxt_start     = 1'b0;
            nxt_cfg_valid = 1'b0;
            trap_cfg = '0;
            trap_cfg.pixel_step      = RST_PIXEL_STEP;
            trap_cfg.iteration_limit = RST_ITERATION_LIMIT;
        end else begin
            if (start && !busy) begin
                trap_results_due.insert(trap_results_due.size(),
                                        predict_orbit(trap_cfg, i_pixel_col, i_pixel_row));
                nxt_start = 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_PIXEL_STEP:      trap_cfg.pixel_step      = i_cfg_data[DIST_W-1:0];
                    REG_CENTRE_REAL:     trap_cfg.centre_real     = i_cfg_data;
                    REG_CENTRE_IMAG:     trap_cfg.centre_imag     = i_cfg_data;
                    REG_TRAP_REAL:       trap_cfg.trap_real       = i_cfg_data;
                    REG_TRAP_IMAG:       trap_cfg.trap_imag       = i_cfg_data;
                    REG_ITERATION_LIMIT: trap_cfg.iteration_limit = i_cfg_data[LIMIT_W-1:0];
                    REG_TRAP_MODE:       trap_cfg.trap_mode       = i_cfg_data[MODE_W-1:0];
                    default: ;
                endcase
                nxt_cfg_valid = 1'b0;
            end
            quiet = trap_results_due.size() == 0 && !o_result_valid && !busy;
            if (!nxt_start && !nxt_cfg_valid && work_q.size() != 0) begin
                w = work_q[0];
                case (w.kind)
                    WORK_PIXEL: if ($urandom_range(99) >= idle_pct) begin
                        i_pixel_col <= w.col;
                        i_pixel_row <= w.row;
                        nxt_start = 1'b1;
                        void'(work_q.pop_front());
                    end
                    WORK_CFG: if (quiet) begin
                        i_cfg_index <= w.index;
                        i_cfg_data  <= w.data;
                        nxt_cfg_valid = 1'b1;
                        void'(work_q.pop_front());
                    end
                    WORK_DRAIN: if (quiet) begin
                        void'(work_q.pop_front());
                    end
                    WORK_IDLE: begin
                        idle_pct = w.idle_pct;
                        void'(work_q.pop_front());
                    end
                endcase
            end
        end
        start       <= nxt_start;
        i_cfg_valid <= nxt_cfg_valid;
    end

    always @(posedge i_clk) begin : monitor
        t_orbit due;
        if (i_rst_n && o_result_valid) begin
            if (trap_results_due.size() == 0) begin
                $error("result word with none due: trap_distance %0d", o_trap_distance);
                fail_count++;
            end else begin
                due = trap_results_due.pop_front();
                if (o_trap_distance !== due.trap_distance) begin
                    $error("trap_distance: expected %0d, actual %0d",
                           due.trap_distance, o_trap_distance);
                    fail_count++;
                end
                if (o_iterations_run !== due.iterations_run) begin
                    $error("iterations_run: expected %0d, actual %0d",
                           due.iterations_run, o_iterations_run);
                    fail_count++;
                end
                if (o_escaped !== due.escaped) begin
                    $error("escaped: expected %0d, actual %0d", due.escaped, o_escaped);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (start && !busy) || o_result_valid || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("escape_time_orbit_trap regression: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : scenario
        int                words;
        int                phase_len;
        int                idle_stage;
        int                r;
        int unsigned       lim;
        logic [WORD_W-1:0] junk;
        logic [WORD_W-1:0] step;

        push_idle(28);
        push_pixel(0, 0);
        push_pixel(-512, -512);
        push_pixel(511, 511);
        push_pixel(-512, 511);
        push_pixel(511, -512);
        push_drain();

        push_cfg(REG_PIXEL_STEP, 32'h0100_0000);
        push_cfg(REG_ITERATION_LIMIT, 32'd20);
        push_cfg(REG_TRAP_MODE, TRAP_CROSS);
        push_pixel(1, 0);
        push_pixel(0, 0);
        push_pixel(-2, 0);
        push_pixel(0, 1);
        push_pixel(-1, 0);

        push_cfg(REG_TRAP_MODE, TRAP_SPARE);
        push_cfg(REG_TRAP_REAL, 32'h0080_0000);
        push_cfg(REG_TRAP_IMAG, 32'hFF80_0000);
        push_pixel(0, 1);
        push_pixel(1, 1);
        push_pixel(-1, 0);

        // drive c and the distances into saturation
        push_cfg(REG_TRAP_MODE, TRAP_EUCLID);
        push_cfg(REG_PIXEL_STEP, 32'h7FFF_FFFF);
        push_cfg(REG_CENTRE_REAL, 32'h7FFF_FFFF);
        push_cfg(REG_CENTRE_IMAG, 32'h8000_0000);
        push_cfg(REG_TRAP_REAL, 32'h8000_0000);
        push_cfg(REG_TRAP_IMAG, 32'h7FFF_FFFF);
        push_pixel(511, -512);
        push_pixel(-512, 511);
        push_pixel(0, 0);
        push_cfg(REG_TRAP_MODE, TRAP_CROSS);
        push_pixel(0, 0);
        push_pixel(1, -1);
        push_cfg(REG_TRAP_MODE, TRAP_VERTICAL);
        push_pixel(0, 0);

        // full-length orbits
        push_cfg(REG_PIXEL_STEP, 32'd0);
        push_cfg(REG_CENTRE_REAL, 32'd0);
        push_cfg(REG_CENTRE_IMAG, 32'd0);
        push_cfg(REG_TRAP_REAL, 32'h0040_0000);
        push_cfg(REG_TRAP_IMAG, 32'h0040_0000);
        push_cfg(REG_ITERATION_LIMIT, LIMIT_MAX);
        push_cfg(REG_TRAP_MODE, TRAP_EUCLID);
        push_pixel(0, 0);
        push_pixel(511, -512);

        push_cfg(REG_ITERATION_LIMIT, 32'd0);
        push_cfg(REG_TRAP_MODE, TRAP_VERTICAL);
        push_cfg(REG_PIXEL_STEP, 32'h0010_0000);
        push_cfg(REG_CENTRE_REAL, 32'hFF00_0000);
        push_pixel(-512, 511);

        words = 0;
        idle_stage = 0;
        while (words < RANDOM_WORDS) begin
            if (idle_stage == 0 && words >= RANDOM_WORDS / 3) begin
                push_idle(84);
                idle_stage = 1;
            end else if (idle_stage == 1 && words >= 2 * RANDOM_WORDS / 3) begin
                push_idle(0);
                idle_stage = 2;
            end

            // keep most orbits short, a few long
            r = $urandom_range(19);
            if (r == 0) begin
                lim = $urandom_range(256, LIMIT_MAX);
                phase_len = 4;
            end else if (r < 4) begin
                lim = $urandom_range(41, 255);
                phase_len = $urandom_range(15, 30);
            end else begin
                lim = $urandom_range(0, 40);
                phase_len = $urandom_range(20, 50);
            end

            r = $urandom_range(19);
            step = (r == 0) ? 32'd0 : (r == 1) ? $urandom : $urandom_range(1 << 13, 1 << 17);
            junk = ($urandom_range(4) == 0) ? $urandom : 32'd0;

            push_cfg(REG_PIXEL_STEP, step);
            push_cfg(REG_CENTRE_REAL, ($urandom_range(9) == 0) ? $urandom :
                     $urandom_range(0, 3 << 24) - (2 << 24));
            push_cfg(REG_CENTRE_IMAG, ($urandom_range(9) == 0) ? $urandom :
                     $urandom_range(0, 3 << 24) - (3 << 23));
            push_cfg(REG_TRAP_REAL, ($urandom_range(6) == 0) ? $urandom :
                     $urandom_range(0, 1 << 26) - (1 << 25));
            push_cfg(REG_TRAP_IMAG, ($urandom_range(6) == 0) ? $urandom :
                     $urandom_range(0, 1 << 26) - (1 << 25));
            push_cfg(REG_ITERATION_LIMIT, {junk[WORD_W-1:LIMIT_W], lim[LIMIT_W-1:0]});
            push_cfg(REG_TRAP_MODE, {junk[WORD_W-1:MODE_W], 2'($urandom_range(3))});

            for (int k = 0; k < phase_len; k++) begin
                if ($urandom_range(59) == 0) push_drain();
                if ($urandom_range(9) == 0)
                    push_pixel(RIM[$urandom_range(3)], RIM[$urandom_range(3)]);
                else
                    push_pixel($urandom_range(1023), $urandom_range(1023));
            end
            words += phase_len;
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk);
        while (work_q.size() != 0 || start || i_cfg_valid || trap_results_due.size() != 0);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (fail_count == 0 && trap_results_due.size() == 0)
            $display("escape_time_orbit_trap regression: pass");
        else
            $display("escape_time_orbit_trap regression: fail");
        $finish;
    end

endmodule
